// File: hdl/leb_pkg.sv
// Shared types and constants for the line edit buffer.
`default_nettype none
package leb_pkg;

  localparam int CHAR_W = 7;   // ASCII character width
  localparam int POS_W  = 7;   // reported cursor / length width
  localparam int OP_W   = 4;

  localparam logic [CHAR_W-1:0] NL_CHAR   = 7'h0A;
  localparam logic [CHAR_W-1:0] PRINT_MIN = 7'h20;
  localparam logic [CHAR_W-1:0] PRINT_MAX = 7'h7E;

  typedef enum logic [OP_W-1:0] {
    OP_CHAR      = 4'd0,
    OP_RIGHT     = 4'd1,
    OP_LEFT      = 4'd2,
    OP_BACKSPACE = 4'd3,
    OP_DELETE    = 4'd4,
    OP_HOME      = 4'd5,
    OP_END       = 4'd6,
    OP_NEWLINE   = 4'd7,
    OP_SUBMIT    = 4'd8,
    OP_NOP       = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_MV,
    ST_INS_PUT,
    ST_DEL_MV,
    ST_SUB_OUT,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

// File: hdl/leb_in_if.sv
// Edit operation channel.
`default_nettype none
interface leb_in_if;
  logic                       valid;
  logic                       ready;
  logic [leb_pkg::OP_W-1:0]   op;
  logic [leb_pkg::CHAR_W-1:0] ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink   (input valid, input op, input ch, output ready);
endinterface
`default_nettype wire

// File: hdl/leb_out_if.sv
// Result channel: status and submitted characters.
`default_nettype none
interface leb_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [leb_pkg::CHAR_W-1:0] out_char;
  logic [leb_pkg::POS_W-1:0]  cursor_pos;
  logic [leb_pkg::POS_W-1:0]  line_length;
  logic                       full_reject;
  logic                       empty_line;
  logic                       last;

  modport source (output valid, output kind, output out_char, output cursor_pos,
                  output line_length, output full_reject, output empty_line,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_char, input cursor_pos,
                  input line_length, input full_reject, input empty_line,
                  input last, output ready);
endinterface
`default_nettype wire

// File: hdl/leb_mem.sv
// Line character store: one write port, one registered read port.
`default_nettype none
module leb_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [leb_pkg::CHAR_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [leb_pkg::CHAR_W-1:0] rd_data
);
  import leb_pkg::*;

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/line_edit_buffer.sv
// Line edit buffer top level: cursor control, shift sequencer and result register.
//
// Holds up to LINE_DEPTH characters with an edit cursor; each accepted edit
// operation returns one status transfer, and submit returns the line one
// character per transfer (empty line: one status flagged empty_line). The
// block takes one operation at a time, driven by a sequencer around a single
// port-pair character RAM. Cursor moves, home, end, nop and rejected inserts
// only produce a status. Insert, delete and backspace shift the characters
// after the cursor, one RAM move per cycle. Submit sends the line one
// character per cycle while the sink takes them. A pending result waits in
// the output register without blocking the next op.
`default_nettype none
module line_edit_buffer #(
  parameter int LINE_DEPTH = 64
) (
  input wire logic clk,
  input wire logic rst_n,
  leb_in_if.sink   in_if,
  leb_out_if.source out_if
);
  import leb_pkg::*;

  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] TWO     = CW'(2);

  state_t state_r, state_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] sub_n_r, sub_n_nxt;
  logic [CHAR_W-1:0] ins_ch_r, ins_ch_nxt;
  logic rej_r, rej_nxt;
  logic empty_r, empty_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_kind_r, out_kind_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [POS_W-1:0] out_cur_r, out_cur_nxt;
  logic [POS_W-1:0] out_len_r, out_len_nxt;
  logic out_rej_r, out_rej_nxt;
  logic out_empty_r, out_empty_nxt;
  logic out_last_r, out_last_nxt;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [CHAR_W-1:0] wr_data, rd_data;
  logic              slot_free, accept, printable, ins_req;
  logic [CW-1:0]     rm_pos;
  logic              rm_req;

  leb_mem #(.DEPTH(LINE_DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign slot_free   = !out_valid_r || out_if.ready;
  assign printable   = (in_if.ch >= PRINT_MIN) && (in_if.ch <= PRINT_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    sub_n_r     <= sub_n_nxt;
    ins_ch_r    <= ins_ch_nxt;
    rej_r       <= rej_nxt;
    empty_r     <= empty_nxt;
    out_kind_r  <= out_kind_nxt;
    out_char_r  <= out_char_nxt;
    out_cur_r   <= out_cur_nxt;
    out_len_r   <= out_len_nxt;
    out_rej_r   <= out_rej_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    sub_n_nxt     = sub_n_r;
    ins_ch_nxt    = ins_ch_r;
    rej_nxt       = rej_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_kind_nxt  = out_kind_r;
    out_char_nxt  = out_char_r;
    out_cur_nxt   = out_cur_r;
    out_len_nxt   = out_len_r;
    out_rej_nxt   = out_rej_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    ins_req       = 1'b0;
    rm_req        = 1'b0;
    rm_pos        = cursor_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rej_nxt    = 1'b0;
          empty_nxt  = 1'b0;
          state_nxt  = ST_RESP;
          ins_ch_nxt = (in_if.op == OP_NEWLINE) ? NL_CHAR : in_if.ch;
          case (in_if.op)
            OP_CHAR:      ins_req = printable;
            OP_NEWLINE:   ins_req = 1'b1;
            OP_RIGHT:     if (cursor_r < fill_r) cursor_nxt = cursor_r + ONE;
            OP_LEFT:      if (cursor_r != '0) cursor_nxt = cursor_r - ONE;
            OP_HOME:      cursor_nxt = '0;
            OP_END:       cursor_nxt = fill_r;
            OP_BACKSPACE: begin
              if (fill_r != '0 && cursor_r != '0) begin
                cursor_nxt = cursor_r - ONE;
                rm_pos     = cursor_r - ONE;
                rm_req     = 1'b1;
              end
            end
            OP_DELETE: begin
              if (fill_r > cursor_r) begin
                rm_req = 1'b1;
              end
            end
            OP_SUBMIT: begin
              if (fill_r == '0) begin
                empty_nxt = 1'b1;
              end else begin
                sub_n_nxt  = fill_r;
                cursor_nxt = '0;
                fill_nxt   = '0;
                idx_nxt    = '0;
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_nxt  = ST_SUB_OUT;
              end
            end
            default: ;
          endcase

          if (ins_req) begin
            if (fill_r == DEPTH_C) begin
              rej_nxt = 1'b1;
            end else if (cursor_r == fill_r) begin
              state_nxt = ST_INS_PUT;
            end else begin
              // shift the tail up, starting from the last character
              rd_en     = 1'b1;
              rd_addr   = AW'(fill_r - ONE);
              idx_nxt   = fill_r;
              state_nxt = ST_INS_MV;
            end
          end

          if (rm_req) begin
            if (rm_pos + ONE < fill_r) begin
              rd_en     = 1'b1;
              rd_addr   = AW'(rm_pos + ONE);
              idx_nxt   = rm_pos;
              state_nxt = ST_DEL_MV;
            end else begin
              fill_nxt = fill_r - ONE;
            end
          end
        end
      end

      ST_INS_MV: begin
        wr_en   = 1'b1;
        wr_addr = AW'(idx_r);
        wr_data = rd_data;
        if (idx_r - ONE > cursor_r) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_r - TWO);
          idx_nxt = idx_r - ONE;
        end else begin
          state_nxt = ST_INS_PUT;
        end
      end

      ST_INS_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = AW'(cursor_r);
        wr_data    = ins_ch_r;
        cursor_nxt = cursor_r + ONE;
        fill_nxt   = fill_r + ONE;
        state_nxt  = ST_RESP;
      end

      ST_DEL_MV: begin
        wr_en   = 1'b1;
        wr_addr = AW'(idx_r);
        wr_data = rd_data;
        if (idx_r + TWO < fill_r) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_r + TWO);
          idx_nxt = idx_r + ONE;
        end else begin
          fill_nxt  = fill_r - ONE;
          state_nxt = ST_RESP;
        end
      end

      ST_SUB_OUT: begin
        // rd_data holds character idx_r until it is loaded
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b1;
          out_char_nxt  = rd_data;
          out_cur_nxt   = '0;
          out_len_nxt   = '0;
          out_rej_nxt   = 1'b0;
          out_empty_nxt = 1'b0;
          out_last_nxt  = (idx_r + ONE == sub_n_r);
          if (idx_r + ONE == sub_n_r) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_r + ONE);
            idx_nxt = idx_r + ONE;
          end
        end
      end

      ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b0;
          out_char_nxt  = '0;
          out_cur_nxt   = POS_W'(cursor_r);
          out_len_nxt   = POS_W'(fill_r);
          out_rej_nxt   = rej_r;
          out_empty_nxt = empty_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.kind        = out_kind_r;
  assign out_if.out_char    = out_char_r;
  assign out_if.cursor_pos  = out_cur_r;
  assign out_if.line_length = out_len_r;
  assign out_if.full_reject = out_rej_r;
  assign out_if.empty_line  = out_empty_r;
  assign out_if.last        = out_last_r;

endmodule
`default_nettype wire

// File: hdl/leb_chk.sv
// Port-level assertions for the line edit buffer, with bind.
`default_nettype none
module leb_chk (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       kind,
  input wire logic [leb_pkg::CHAR_W-1:0] out_char,
  input wire logic [leb_pkg::POS_W-1:0]  cursor_pos,
  input wire logic [leb_pkg::POS_W-1:0]  line_length,
  input wire logic                       full_reject,
  input wire logic                       empty_line,
  input wire logic                       last
);
  import leb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_char)
      && $stable(last) && $stable(cursor_pos) && $stable(line_length))
    else $error("result changed while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !kind |-> last)
    else $error("status transfer without last");

  a_char_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind |-> cursor_pos == '0 && line_length == '0
      && !full_reject && !empty_line)
    else $error("submitted character with stale status");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && empty_line |-> !kind && line_length == '0 && cursor_pos == '0)
    else $error("empty line flag on non-empty state");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && full_reject |-> !kind && !empty_line)
    else $error("full reject on wrong transfer");

endmodule

bind line_edit_buffer leb_chk u_leb_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .kind        (out_if.kind),
  .out_char    (out_if.out_char),
  .cursor_pos  (out_if.cursor_pos),
  .line_length (out_if.line_length),
  .full_reject (out_if.full_reject),
  .empty_line  (out_if.empty_line),
  .last        (out_if.last)
);
`default_nettype wire

// File: verif/line_edit_buffer_tb.sv
// Self-checking testbench for the line edit buffer: directed edits, full line, random editing.
`timescale 1ns / 100ps
module line_edit_buffer_tb;
  import leb_pkg::*;

  localparam int LINE_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] out_char;
    logic [POS_W-1:0]  cursor_pos;
    logic [POS_W-1:0]  line_length;
    logic              full_reject;
    logic              empty_line;
    logic              last;
  } edit_result_t;

  logic clk = 1'b0;
  logic rst_n;

  leb_in_if  edit_ch ();
  leb_out_if result_ch ();

  line_edit_buffer #(.LINE_DEPTH(LINE_DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (edit_ch),
    .out_if (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the line held by the block
  logic [CHAR_W-1:0] line_model [LINE_DEPTH];
  int                caret;
  int                line_len;
  edit_result_t      pending_results [$];

  int src_idle_pct;
  int snk_idle_pct;
  int err_count;
  int edits_sent;
  int results_seen;
  int lines_drained;
  int cycle_count;

  function automatic string fmt_result(edit_result_t r);
    return $sformatf("kind=%0d char=%02h cur=%0d len=%0d rej=%0d empty=%0d last=%0d",
                     r.kind, r.out_char, r.cursor_pos, r.line_length, r.full_reject,
                     r.empty_line, r.last);
  endfunction

  function automatic void note_result(logic kind, logic [CHAR_W-1:0] c, logic rej,
                                      logic empty, logic fin);
    edit_result_t r;
    r.kind        = kind;
    r.out_char    = c;
    r.cursor_pos  = POS_W'(caret);
    r.line_length = POS_W'(line_len);
    r.full_reject = rej;
    r.empty_line  = empty;
    r.last        = fin;
    pending_results.push_back(r);
  endfunction

  // Returns 1 when the line is full and the character is dropped
  function automatic logic line_insert(logic [CHAR_W-1:0] c);
    if (line_len >= LINE_DEPTH) return 1'b1;
    for (int i = line_len; i > caret; i--) line_model[i] = line_model[i-1];
    line_model[caret] = c;
    caret++;
    line_len++;
    return 1'b0;
  endfunction

  function automatic void line_remove(int pos);
    for (int i = pos; i + 1 < line_len; i++) line_model[i] = line_model[i+1];
    line_len--;
  endfunction

  function automatic void apply_edit(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch);
    logic rej;
    int   n;
    rej = 1'b0;
    case (op)
      OP_CHAR: begin
        if (ch >= PRINT_MIN && ch <= PRINT_MAX) rej = line_insert(ch);
      end
      OP_RIGHT:     if (caret < line_len) caret++;
      OP_LEFT:      if (caret > 0) caret--;
      OP_BACKSPACE: begin
        if (caret > 0) begin
          caret--;
          line_remove(caret);
        end
      end
      OP_DELETE:    if (caret < line_len) line_remove(caret);
      OP_HOME:      caret = 0;
      OP_END:       caret = line_len;
      OP_NEWLINE:   rej = line_insert(NL_CHAR);
      OP_SUBMIT: begin
        if (line_len == 0) begin
          note_result(1'b0, '0, 1'b0, 1'b1, 1'b1);
        end else begin
          // status fields report the cleared line on every drained character
          n        = line_len;
          caret    = 0;
          line_len = 0;
          for (int i = 0; i < n; i++)
            note_result(1'b1, line_model[i], 1'b0, 1'b0, i == n - 1);
          lines_drained++;
        end
        return;
      end
      default: ;
    endcase
    note_result(1'b0, '0, rej, 1'b0, 1'b1);
  endfunction

  task automatic send_edit(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk);
      edit_ch.valid = 1'b0;
    end
    @(negedge clk);
    edit_ch.valid = 1'b1;
    edit_ch.op    = op;
    edit_ch.ch    = ch;
    @(posedge clk);
    while (!edit_ch.ready) @(posedge clk);
    apply_edit(op, ch);
    edits_sent++;
  endtask

  task automatic wait_drained;
    @(negedge clk);
    edit_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    edit_result_t got;
    edit_result_t want;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      got.kind        = result_ch.kind;
      got.out_char    = result_ch.out_char;
      got.cursor_pos  = result_ch.cursor_pos;
      got.line_length = result_ch.line_length;
      got.full_reject = result_ch.full_reject;
      got.empty_line  = result_ch.empty_line;
      got.last        = result_ch.last;
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %s", $time, fmt_result(got));
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch, expected %s, got %s", $time, fmt_result(want),
                   fmt_result(got));
          err_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (cycle_count > 0) result_ch.ready = ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_empty_line_bounds;
    send_edit(OP_SUBMIT, '0);
    send_edit(OP_LEFT, '0);
    send_edit(OP_BACKSPACE, 7'h7F);
    send_edit(OP_RIGHT, '0);
    send_edit(OP_DELETE, 7'h55);
  endtask

  task automatic test_char_classes;
    send_edit(OP_CHAR, 7'h1F);
    send_edit(OP_CHAR, 7'h7F);
    send_edit(OP_CHAR, 7'h20);
    send_edit(OP_CHAR, 7'h7E);
    send_edit(OP_NEWLINE, 7'h2A);
    send_edit(OP_CHAR, 7'h41);
  endtask

  task automatic test_cursor_edits;
    send_edit(OP_LEFT, '0);
    send_edit(OP_LEFT, '0);
    send_edit(OP_BACKSPACE, '0);
    send_edit(OP_DELETE, '0);
    send_edit(OP_HOME, '0);
    send_edit(OP_RIGHT, '0);
    send_edit(OP_END, '0);
  endtask

  // op 9 and the unused codes above it leave the line alone
  task automatic test_idle_ops;
    for (int k = OP_NOP; k < 16; k++) send_edit(OP_W'(k), 7'($urandom_range(0, 127)));
    send_edit(OP_SUBMIT, '0);
  endtask

  task automatic test_full_line;
    for (int k = 0; k < LINE_DEPTH; k++) begin
      if (k == LINE_DEPTH / 2) send_edit(OP_HOME, '0);
      if ($urandom_range(0, 7) == 0) send_edit(OP_NEWLINE, 7'($urandom_range(0, 127)));
      else send_edit(OP_CHAR, 7'($urandom_range(32, 126)));
    end
    send_edit(OP_CHAR, 7'h5A);
    send_edit(OP_NEWLINE, '0);
    send_edit(OP_END, '0);
    send_edit(OP_CHAR, 7'h30);
    send_edit(OP_BACKSPACE, '0);
    send_edit(OP_CHAR, 7'h7E);
    send_edit(OP_SUBMIT, '0);
  endtask

  task automatic test_random_edits(int count);
    int                pick;
    logic [CHAR_W-1:0] ch;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      ch   = 7'($urandom_range(0, 127));
      if (pick < 45) begin
        if ($urandom_range(0, 99) < 85) ch = 7'($urandom_range(32, 126));
        send_edit(OP_CHAR, ch);
      end
      else if (pick < 53) send_edit(OP_NEWLINE, ch);
      else if (pick < 61) send_edit(OP_RIGHT, ch);
      else if (pick < 69) send_edit(OP_LEFT, ch);
      else if (pick < 77) send_edit(OP_BACKSPACE, ch);
      else if (pick < 85) send_edit(OP_DELETE, ch);
      else if (pick < 89) send_edit(OP_HOME, ch);
      else if (pick < 93) send_edit(OP_END, ch);
      else if (pick < 96) send_edit(OP_W'($urandom_range(OP_NOP, 15)), ch);
      else send_edit(OP_SUBMIT, ch);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    edit_ch.valid   = 1'b0;
    edit_ch.op      = OP_NOP;
    edit_ch.ch      = '0;
    result_ch.ready = 1'b0;
    err_count       = 0;
    edits_sent      = 0;
    results_seen    = 0;
    lines_drained   = 0;
    cycle_count     = 0;
    caret           = 0;
    line_len        = 0;
    src_idle_pct    = 29;
    snk_idle_pct    = 85;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_empty_line_bounds();
    test_char_classes();
    test_cursor_edits();
    test_idle_ops();
    test_full_line();
    test_random_edits(65);
    wait_drained();

    src_idle_pct = 85;
    snk_idle_pct = 29;
    test_random_edits(65);
    wait_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_edits(70);
    wait_drained();

    repeat (LINE_DEPTH + 8) @(posedge clk);
    $display("Covered %0d edits (bounds, char classes, full line, random), %0d results checked,",
             edits_sent, results_seen);
    $display("%0d lines drained by submit, %0d mismatches", lines_drained, err_count);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/leb_pkg.sv
hdl/leb_in_if.sv
hdl/leb_out_if.sv
hdl/leb_mem.sv
hdl/line_edit_buffer.sv
hdl/leb_chk.sv
verif/line_edit_buffer_tb.sv
